// File: src/axis_rect_ray_intersect_assert.svh
// Assertion macros for the rectangle ray test block.
`ifndef AXIS_RECT_RAY_INTERSECT_ASSERT_SVH
`define AXIS_RECT_RAY_INTERSECT_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define RRI_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
`define RRI_ASSERT_NR(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);
`else
`define RRI_ASSERT(lbl, prop, msg)
`define RRI_ASSERT_NR(lbl, prop, msg)
`endif
`endif

// File: src/rri_pkg.sv
// Types and constants shared by the rectangle ray test block.
package rri_pkg;

    localparam int FRAC_BITS = 16;
    localparam int NUM_W     = 33 + FRAC_BITS;
    localparam int DEN_W     = 32;
    localparam int P_W       = 64 - FRAC_BITS + 1;
    localparam int UV_BITS   = 16;
    localparam logic [UV_BITS:0] UV_ONE = {1'b1, {UV_BITS{1'b0}}};

    localparam logic [1:0] AXIS_XY = 2'd0;
    localparam logic [1:0] AXIS_XZ = 2'd1;
    localparam logic [1:0] AXIS_YZ = 2'd2;

    localparam logic [2:0] REG_PLANE_AXIS  = 3'd0;
    localparam logic [2:0] REG_LO_A        = 3'd1;
    localparam logic [2:0] REG_HI_A        = 3'd2;
    localparam logic [2:0] REG_LO_B        = 3'd3;
    localparam logic [2:0] REG_HI_B        = 3'd4;
    localparam logic [2:0] REG_PLANE_K     = 3'd5;
    localparam logic [2:0] REG_FLIP_NORMAL = 3'd6;
    localparam logic [2:0] REG_MATERIAL_ID = 3'd7;

    typedef struct packed {
        logic signed [31:0] origin_x;
        logic signed [31:0] origin_y;
        logic signed [31:0] origin_z;
        logic signed [31:0] dir_x;
        logic signed [31:0] dir_y;
        logic signed [31:0] dir_z;
        logic signed [31:0] t_min;
        logic signed [31:0] t_max;
    } t_in;

    typedef struct packed {
        logic               hit;
        logic signed [31:0] hit_t;
        logic [16:0]        tex_u;
        logic [16:0]        tex_v;
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic signed [31:0] point_z;
        logic               normal_negative;
        logic [15:0]        hit_material;
    } t_out;

    typedef struct packed {
        t_in  ray;
        logic neg;
        logic dzero;
    } t_side;

endpackage

// File: src/rri_tdiv.sv
// Pipelined restoring divider for the ray parameter, one quotient bit per stage.
module rri_tdiv (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_en,
    input  logic                       i_valid,
    input  logic [rri_pkg::NUM_W-1:0]  i_num,
    input  logic [rri_pkg::DEN_W-1:0]  i_den,
    input  rri_pkg::t_side             i_side,
    output logic                       o_valid,
    output logic [rri_pkg::NUM_W-1:0]  o_quo,
    output rri_pkg::t_side             o_side
);
    import rri_pkg::*;

    logic             r_vld  [NUM_W];
    logic [DEN_W-1:0] r_rem  [NUM_W];
    logic [DEN_W-1:0] r_den  [NUM_W];
    logic [NUM_W-1:0] r_dvd  [NUM_W];
    t_side            r_side [NUM_W];

    for (genvar k = 0; k < NUM_W; k++) begin : g_step
        logic             p_vld;
        logic [DEN_W-1:0] p_rem;
        logic [DEN_W-1:0] p_den;
        logic [NUM_W-1:0] p_dvd;
        t_side            p_side;
        logic [DEN_W:0]   trial;
        logic             ge;
        logic [DEN_W-1:0] n_rem;
        logic [NUM_W-1:0] n_dvd;

        if (k == 0) begin : g_first
            assign p_vld  = i_valid;
            assign p_rem  = '0;
            assign p_den  = i_den;
            assign p_dvd  = i_num;
            assign p_side = i_side;
        end else begin : g_next
            assign p_vld  = r_vld[k-1];
            assign p_rem  = r_rem[k-1];
            assign p_den  = r_den[k-1];
            assign p_dvd  = r_dvd[k-1];
            assign p_side = r_side[k-1];
        end

        assign trial = {p_rem, p_dvd[NUM_W-1]};
        assign ge    = trial >= {1'b0, p_den};
        assign n_rem = ge ? DEN_W'(trial - {1'b0, p_den}) : trial[DEN_W-1:0];
        assign n_dvd = {p_dvd[NUM_W-2:0], ge};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (i_en) begin
                r_vld[k] <= p_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k]  <= n_rem;
                r_den[k]  <= p_den;
                r_dvd[k]  <= n_dvd;
                r_side[k] <= p_side;
            end
        end
    end

    assign o_valid = r_vld[NUM_W-1];
    assign o_quo   = r_dvd[NUM_W-1];
    assign o_side  = r_side[NUM_W-1];

endmodule

// File: src/axis_rect_ray_intersect.sv
// An accepted ray passes the input register, the parameter divider, stages A to D,
// the u/v divider and the output register. Throughput: one ray per cycle unless the
// output stalls; the 49-stage parameter divider and the 16-stage u/v divider are fully
// pipelined, one quotient bit per stage. A stall of a valid output freezes the whole pipeline for that cycle.
// Reset clears stage valid bits and loads the register reset values.
`include "axis_rect_ray_intersect_assert.svh"
module axis_rect_ray_intersect (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    input  rri_pkg::t_in  i_data,
    output logic          o_valid,
    input  logic          i_stall,
    output rri_pkg::t_out o_data,
    input  logic          i_cfg_valid,
    output logic          o_cfg_ready,
    input  logic [2:0]    i_cfg_index,
    input  logic [31:0]   i_cfg_data
);
    import rri_pkg::*;

    function automatic logic signed [31:0] sat32(input logic signed [P_W-1:0] v);
        logic signed [P_W-1:0] hi;
        logic signed [P_W-1:0] lo;
        hi = {{(P_W-31){1'b0}}, {31{1'b1}}};
        lo = {{(P_W-31){1'b1}}, {31{1'b0}}};
        if (v > hi) return 32'sh7fffffff;
        if (v < lo) return 32'sh80000000;
        return v[31:0];
    endfunction

    logic              en;

    logic [1:0]         r_plane_axis;
    logic signed [31:0] r_lo_a, r_hi_a, r_lo_b, r_hi_b, r_plane_k;
    logic               r_flip_normal;
    logic [15:0]        r_material_id;

    assign en          = !(o_valid && i_stall);
    assign o_stall     = !en;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_plane_axis  <= AXIS_XY;
            r_lo_a        <= 32'sd0;
            r_hi_a        <= 32'sd65536;
            r_lo_b        <= 32'sd0;
            r_hi_b        <= 32'sd65536;
            r_plane_k     <= 32'sd0;
            r_flip_normal <= 1'b0;
            r_material_id <= 16'd0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                REG_PLANE_AXIS:  r_plane_axis  <= i_cfg_data[1:0];
                REG_LO_A:        r_lo_a        <= i_cfg_data;
                REG_HI_A:        r_hi_a        <= i_cfg_data;
                REG_LO_B:        r_lo_b        <= i_cfg_data;
                REG_HI_B:        r_hi_b        <= i_cfg_data;
                REG_PLANE_K:     r_plane_k     <= i_cfg_data;
                REG_FLIP_NORMAL: r_flip_normal <= i_cfg_data[0];
                REG_MATERIAL_ID: r_material_id <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // input stage: pick normal axis, form |k - o| << FRAC_BITS and |d|
    logic signed [31:0] s0_on, s0_dn;
    logic signed [32:0] s0_num;
    logic [32:0]        s0_mag;
    logic [DEN_W-1:0]   s0_dmag;

    always_comb begin
        case (r_plane_axis)
            AXIS_XY: begin
                s0_on = i_data.origin_z;
                s0_dn = i_data.dir_z;
            end
            AXIS_XZ: begin
                s0_on = i_data.origin_y;
                s0_dn = i_data.dir_y;
            end
            default: begin
                s0_on = i_data.origin_x;
                s0_dn = i_data.dir_x;
            end
        endcase
    end

    assign s0_num  = {r_plane_k[31], r_plane_k} - {s0_on[31], s0_on};
    assign s0_mag  = s0_num[32] ? 33'(-s0_num) : s0_num;
    assign s0_dmag = s0_dn[31] ? DEN_W'(-s0_dn) : s0_dn;

    logic             r0_vld;
    logic [NUM_W-1:0] r0_num;
    logic [DEN_W-1:0] r0_den;
    t_side            r0_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_vld <= 1'b0;
        end else if (en) begin
            r0_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r0_num        <= {s0_mag, {FRAC_BITS{1'b0}}};
            r0_den        <= s0_dmag;
            r0_side.ray   <= i_data;
            r0_side.neg   <= s0_num[32] ^ s0_dn[31];
            r0_side.dzero <= s0_dn == 32'sd0;
        end
    end

    logic             dv_vld;
    logic [NUM_W-1:0] dv_quo;
    t_side            dv_side;

    rri_tdiv u_tdiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r0_vld),
        .i_num   (r0_num),
        .i_den   (r0_den),
        .i_side  (r0_side),
        .o_valid (dv_vld),
        .o_quo   (dv_quo),
        .o_side  (dv_side)
    );

    // stage A: sign, interval test, saturate
    logic signed [NUM_W:0] a_t, a_tmin, a_tmax, a_max, a_min;
    logic                  a_unb, a_miss;
    logic signed [31:0]    a_tsat;

    assign a_t    = dv_side.neg ? -$signed({1'b0, dv_quo}) : $signed({1'b0, dv_quo});
    assign a_tmin = {{(NUM_W-31){dv_side.ray.t_min[31]}}, dv_side.ray.t_min};
    assign a_tmax = {{(NUM_W-31){dv_side.ray.t_max[31]}}, dv_side.ray.t_max};
    assign a_max  = {{(NUM_W-30){1'b0}}, {31{1'b1}}};
    assign a_min  = {{(NUM_W-30){1'b1}}, {31{1'b0}}};
    assign a_unb  = dv_side.ray.t_max == 32'sh7fffffff;
    assign a_miss = dv_side.dzero || (a_t < a_tmin) || (!a_unb && (a_t > a_tmax));
    assign a_tsat = (a_t > a_max) ? 32'sh7fffffff :
                    (a_t < a_min) ? 32'sh80000000 : a_t[31:0];

    logic               ra_vld, ra_miss;
    logic signed [31:0] ra_t;
    t_in                ra_ray;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            ra_vld <= 1'b0;
        end else if (en) begin
            ra_vld <= dv_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            ra_miss <= a_miss;
            ra_t    <= a_tsat;
            ra_ray  <= dv_side.ray;
        end
    end

    // stage B: t * d per axis
    logic               rb_vld, rb_miss;
    logic signed [31:0] rb_t;
    t_in                rb_ray;
    logic signed [63:0] rb_px, rb_py, rb_pz;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            rb_vld <= 1'b0;
        end else if (en) begin
            rb_vld <= ra_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            rb_miss <= ra_miss;
            rb_t    <= ra_t;
            rb_ray  <= ra_ray;
            rb_px   <= ra_t * ra_ray.dir_x;
            rb_py   <= ra_t * ra_ray.dir_y;
            rb_pz   <= ra_t * ra_ray.dir_z;
        end
    end

    // stage C: hit point, full precision
    logic signed [63:0]    c_sx, c_sy, c_sz;
    logic signed [P_W-1:0] c_x, c_y, c_z;

    assign c_sx = rb_px >>> FRAC_BITS;
    assign c_sy = rb_py >>> FRAC_BITS;
    assign c_sz = rb_pz >>> FRAC_BITS;
    assign c_x  = {{(P_W-32){rb_ray.origin_x[31]}}, rb_ray.origin_x} + c_sx[P_W-1:0];
    assign c_y  = {{(P_W-32){rb_ray.origin_y[31]}}, rb_ray.origin_y} + c_sy[P_W-1:0];
    assign c_z  = {{(P_W-32){rb_ray.origin_z[31]}}, rb_ray.origin_z} + c_sz[P_W-1:0];

    logic                  rc_vld, rc_miss;
    logic signed [31:0]    rc_t;
    logic signed [P_W-1:0] rc_x, rc_y, rc_z;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            rc_vld <= 1'b0;
        end else if (en) begin
            rc_vld <= rb_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            rc_miss <= rb_miss;
            rc_t    <= rb_t;
            rc_x    <= c_x;
            rc_y    <= c_y;
            rc_z    <= c_z;
        end
    end

    // stage D: bounds test and u/v divider setup
    logic signed [P_W-1:0] d_pa, d_pb, d_la, d_lb, d_ha, d_hb, d_xa, d_xb;
    logic signed [32:0]    d_spa, d_spb;
    logic                  d_hit, d_one_u, d_one_v, d_nz_u, d_nz_v;
    t_out                  d_res;

    always_comb begin
        case (r_plane_axis)
            AXIS_XY: begin
                d_pa = rc_x;
                d_pb = rc_y;
            end
            AXIS_XZ: begin
                d_pa = rc_x;
                d_pb = rc_z;
            end
            default: begin
                d_pa = rc_y;
                d_pb = rc_z;
            end
        endcase
    end

    assign d_la   = {{(P_W-32){r_lo_a[31]}}, r_lo_a};
    assign d_ha   = {{(P_W-32){r_hi_a[31]}}, r_hi_a};
    assign d_lb   = {{(P_W-32){r_lo_b[31]}}, r_lo_b};
    assign d_hb   = {{(P_W-32){r_hi_b[31]}}, r_hi_b};
    assign d_hit  = !rc_miss && (d_pa >= d_la) && (d_pa <= d_ha) &&
                    (d_pb >= d_lb) && (d_pb <= d_hb);
    assign d_xa   = d_pa - d_la;
    assign d_xb   = d_pb - d_lb;
    assign d_spa  = {r_hi_a[31], r_hi_a} - {r_lo_a[31], r_lo_a};
    assign d_spb  = {r_hi_b[31], r_hi_b} - {r_lo_b[31], r_lo_b};
    assign d_nz_u = d_hit && (d_spa != 33'sd0);
    assign d_nz_v = d_hit && (d_spb != 33'sd0);
    assign d_one_u = d_nz_u && (d_xa[32:0] == d_spa);
    assign d_one_v = d_nz_v && (d_xb[32:0] == d_spb);

    always_comb begin
        d_res                 = '0;
        d_res.hit             = d_hit;
        d_res.hit_t           = d_hit ? rc_t : 32'sd0;
        d_res.point_x         = d_hit ? sat32(rc_x) : 32'sd0;
        d_res.point_y         = d_hit ? sat32(rc_y) : 32'sd0;
        d_res.point_z         = d_hit ? sat32(rc_z) : 32'sd0;
        d_res.normal_negative = d_hit && r_flip_normal;
        d_res.hit_material    = d_hit ? r_material_id : 16'd0;
    end

    logic        rd_vld, rd_one_u, rd_one_v;
    logic [32:0] rd_rem_u, rd_rem_v, rd_sp_u, rd_sp_v;
    t_out        rd_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            rd_vld <= 1'b0;
        end else if (en) begin
            rd_vld <= rc_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            rd_res   <= d_res;
            rd_one_u <= d_one_u;
            rd_one_v <= d_one_v;
            rd_rem_u <= (d_nz_u && !d_one_u) ? d_xa[32:0] : 33'd0;
            rd_rem_v <= (d_nz_v && !d_one_v) ? d_xb[32:0] : 33'd0;
            rd_sp_u  <= d_nz_u ? d_spa : 33'd1;
            rd_sp_v  <= d_nz_v ? d_spb : 33'd1;
        end
    end

    // u/v divider: one fraction bit per stage
    logic               r_uv_vld   [UV_BITS];
    logic [32:0]        r_rem_u    [UV_BITS];
    logic [32:0]        r_rem_v    [UV_BITS];
    logic [32:0]        r_sp_u     [UV_BITS];
    logic [32:0]        r_sp_v     [UV_BITS];
    logic [UV_BITS-1:0] r_q_u      [UV_BITS];
    logic [UV_BITS-1:0] r_q_v      [UV_BITS];
    logic               r_one_u    [UV_BITS];
    logic               r_one_v    [UV_BITS];
    t_out               r_uv_res   [UV_BITS];

    for (genvar k = 0; k < UV_BITS; k++) begin : g_uv
        logic               p_vld, p_one_u, p_one_v;
        logic [32:0]        p_rem_u, p_rem_v, p_sp_u, p_sp_v;
        logic [UV_BITS-1:0] p_q_u, p_q_v;
        t_out               p_res;
        logic [33:0]        tr_u, tr_v;
        logic               ge_u, ge_v;

        if (k == 0) begin : g_first
            assign p_vld   = rd_vld;
            assign p_one_u = rd_one_u;
            assign p_one_v = rd_one_v;
            assign p_rem_u = rd_rem_u;
            assign p_rem_v = rd_rem_v;
            assign p_sp_u  = rd_sp_u;
            assign p_sp_v  = rd_sp_v;
            assign p_q_u   = '0;
            assign p_q_v   = '0;
            assign p_res   = rd_res;
        end else begin : g_next
            assign p_vld   = r_uv_vld[k-1];
            assign p_one_u = r_one_u[k-1];
            assign p_one_v = r_one_v[k-1];
            assign p_rem_u = r_rem_u[k-1];
            assign p_rem_v = r_rem_v[k-1];
            assign p_sp_u  = r_sp_u[k-1];
            assign p_sp_v  = r_sp_v[k-1];
            assign p_q_u   = r_q_u[k-1];
            assign p_q_v   = r_q_v[k-1];
            assign p_res   = r_uv_res[k-1];
        end

        assign tr_u = {p_rem_u, 1'b0};
        assign tr_v = {p_rem_v, 1'b0};
        assign ge_u = tr_u >= {1'b0, p_sp_u};
        assign ge_v = tr_v >= {1'b0, p_sp_v};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_uv_vld[k] <= 1'b0;
            end else if (en) begin
                r_uv_vld[k] <= p_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_rem_u[k]  <= ge_u ? 33'(tr_u - {1'b0, p_sp_u}) : tr_u[32:0];
                r_rem_v[k]  <= ge_v ? 33'(tr_v - {1'b0, p_sp_v}) : tr_v[32:0];
                r_q_u[k]    <= {p_q_u[UV_BITS-2:0], ge_u};
                r_q_v[k]    <= {p_q_v[UV_BITS-2:0], ge_v};
                r_sp_u[k]   <= p_sp_u;
                r_sp_v[k]   <= p_sp_v;
                r_one_u[k]  <= p_one_u;
                r_one_v[k]  <= p_one_v;
                r_uv_res[k] <= p_res;
            end
        end
    end

    t_out n_out;
    logic r_out_vld;
    t_out r_out;

    always_comb begin
        n_out       = r_uv_res[UV_BITS-1];
        n_out.tex_u = r_one_u[UV_BITS-1] ? UV_ONE : {1'b0, r_q_u[UV_BITS-1]};
        n_out.tex_v = r_one_v[UV_BITS-1] ? UV_ONE : {1'b0, r_q_v[UV_BITS-1]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (en) begin
            r_out_vld <= r_uv_vld[UV_BITS-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out <= n_out;
        end
    end

    assign o_valid = r_out_vld;
    assign o_data  = r_out;

    `RRI_ASSERT(a_miss_zero, o_valid && !o_data.hit |-> o_data == t_out'('0), "miss not zero")
    `RRI_ASSERT(a_hit_tags, o_valid && o_data.hit |-> o_data.normal_negative == r_flip_normal && o_data.hit_material == r_material_id, "hit tags wrong")
    `RRI_ASSERT(a_tex_range, o_valid && o_data.hit |-> o_data.tex_u <= UV_ONE && o_data.tex_v <= UV_ONE, "tex out of range")
    `RRI_ASSERT_NR(a_stall_src, o_stall |-> o_valid && i_stall, "stall without held result")

endmodule

// File: verif/tb_axis_rect_ray_intersect.sv
// Self-checking testbench for the axis-aligned rectangle ray test block.
`timescale 1ns / 100ps
module tb_axis_rect_ray_intersect;
    import rri_pkg::*;

    localparam logic [1:0] AXIS_YZ_ALIAS = 2'd3;
    localparam int         LATENCY_WAIT  = 90;
    localparam int         CYCLE_LIMIT   = 400000;
    localparam longint     I32_MAX       = 64'sd2147483647;
    localparam longint     I32_MIN       = -64'sd2147483648;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    t_in         i_data;
    logic        o_valid;
    logic        i_stall;
    t_out        o_data;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index;
    logic [31:0] i_cfg_data;

    axis_rect_ray_intersect dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_data      (i_data),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_data      (o_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // shadow copy of the rectangle registers
    logic [1:0]         m_axis;
    logic signed [31:0] m_lo_a, m_hi_a, m_lo_b, m_hi_b, m_k;
    logic               m_flip;
    logic [15:0]        m_material;

    t_in  ray_queue[$];
    t_out hit_queue[$];
    int   n_errors, n_rays, n_hits, n_misses, n_cycles;
    int   send_gap, recv_gap;
    logic send_burst, recv_burst;
    int   hold_req, hold_done, hold_cnt;

    always begin
        i_clk = 1'b0;
        #1;
        i_clk = 1'b1;
        #1;
    end

    function automatic longint sat32(longint v);
        if (v > I32_MAX) return I32_MAX;
        if (v < I32_MIN) return I32_MIN;
        return v;
    endfunction

    function automatic logic [16:0] to_unit(longint x, longint lo, longint hi);
        longint span;
        span = hi - lo;
        if (span <= 0) return '0;
        return 17'(((x - lo) * 65536) / span);
    endfunction

    function automatic t_out trace_rect(t_in r);
        t_out   res;
        longint o[3], d[3], p[3];
        longint t, tmin, tmax, la, ha, lb, hb;
        int     n, ia, ib;
        res = '0;
        o[0] = r.origin_x; o[1] = r.origin_y; o[2] = r.origin_z;
        d[0] = r.dir_x;    d[1] = r.dir_y;    d[2] = r.dir_z;
        tmin = r.t_min; tmax = r.t_max;
        la = m_lo_a; ha = m_hi_a; lb = m_lo_b; hb = m_hi_b;
        case (m_axis)
            AXIS_XY: begin n = 2; ia = 0; ib = 1; end
            AXIS_XZ: begin n = 1; ia = 0; ib = 2; end
            default: begin n = 0; ia = 1; ib = 2; end
        endcase
        if (d[n] == 0) return res;
        t = ((longint'(m_k) - o[n]) * (64'sd1 <<< FRAC_BITS)) / d[n];
        if (t < tmin) return res;
        if (tmax != I32_MAX && t > tmax) return res;
        t = sat32(t);
        for (int i = 0; i < 3; i++) p[i] = o[i] + ((t * d[i]) >>> FRAC_BITS);
        if (p[ia] < la || p[ia] > ha || p[ib] < lb || p[ib] > hb) return res;
        res.hit             = 1'b1;
        res.hit_t           = 32'(t);
        res.tex_u           = to_unit(p[ia], la, ha);
        res.tex_v           = to_unit(p[ib], lb, hb);
        res.point_x         = 32'(sat32(p[0]));
        res.point_y         = 32'(sat32(p[1]));
        res.point_z         = 32'(sat32(p[2]));
        res.normal_negative = m_flip;
        res.hit_material    = m_material;
        return res;
    endfunction

    function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, act_v);
            n_errors++;
        end
    endfunction

    // ray source
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid    <= 1'b0;
            i_data     <= '0;
            send_gap   <= 0;
            send_burst <= 1'b0;
        end else begin
            if (i_valid && !o_stall) begin
                hit_queue.push_back(trace_rect(i_data));
                n_rays++;
            end
            if ($urandom_range(0, 99) == 0) send_burst <= ~send_burst;
            if (!i_valid || !o_stall) begin
                if (send_gap > 0) begin
                    send_gap <= send_gap - 1;
                    i_valid  <= 1'b0;
                end else if (ray_queue.size() > 0) begin
                    i_data   <= ray_queue.pop_front();
                    i_valid  <= 1'b1;
                    send_gap <= send_burst ? 0 : $urandom_range(0, 5);
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // result sink
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall    <= 1'b0;
            recv_gap   <= 0;
            recv_burst <= 1'b0;
            hold_cnt   <= 0;
            hold_done  <= 0;
        end else begin
            if (o_valid && !i_stall) begin
                if (hit_queue.size() == 0) begin
                    $display("%0t: unexpected transaction, actual %h", $time, o_data);
                    n_errors++;
                end else begin
                    t_out e;
                    e = hit_queue.pop_front();
                    if (e.hit) n_hits++; else n_misses++;
                    check_field("hit", e.hit, o_data.hit);
                    check_field("hit_t", e.hit_t, o_data.hit_t);
                    check_field("tex_u", e.tex_u, o_data.tex_u);
                    check_field("tex_v", e.tex_v, o_data.tex_v);
                    check_field("point_x", e.point_x, o_data.point_x);
                    check_field("point_y", e.point_y, o_data.point_y);
                    check_field("point_z", e.point_z, o_data.point_z);
                    check_field("normal_negative", e.normal_negative,
                                o_data.normal_negative);
                    check_field("hit_material", e.hit_material, o_data.hit_material);
                end
                recv_gap <= recv_burst ? 0 : $urandom_range(0, 5);
            end
            if ($urandom_range(0, 99) == 0) recv_burst <= ~recv_burst;
            if (hold_cnt > 0) begin
                hold_cnt <= hold_cnt - 1;
                i_stall  <= 1'b1;
            end else if (hold_req != hold_done) begin
                hold_done <= hold_req;
                hold_cnt  <= 300;
                i_stall   <= 1'b1;
            end else if (recv_gap > 0 && !(o_valid && !i_stall)) begin
                recv_gap <= recv_gap - 1;
                i_stall  <= 1'b1;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        n_cycles++;
        if (n_cycles > CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic write_reg(logic [2:0] idx, logic [31:0] val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        case (idx)
            REG_PLANE_AXIS:  m_axis     = val[1:0];
            REG_LO_A:        m_lo_a     = val;
            REG_HI_A:        m_hi_a     = val;
            REG_LO_B:        m_lo_b     = val;
            REG_HI_B:        m_hi_b     = val;
            REG_PLANE_K:     m_k        = val;
            REG_FLIP_NORMAL: m_flip     = val[0];
            REG_MATERIAL_ID: m_material = val[15:0];
            default: ;
        endcase
    endtask

    task automatic set_rect(logic [1:0] ax, longint la, longint ha, longint lb,
                            longint hb, longint k, logic flip, logic [15:0] mat);
        write_reg(REG_PLANE_AXIS, 32'(ax));
        write_reg(REG_LO_A, 32'(la));
        write_reg(REG_HI_A, 32'(ha));
        write_reg(REG_LO_B, 32'(lb));
        write_reg(REG_HI_B, 32'(hb));
        write_reg(REG_PLANE_K, 32'(k));
        write_reg(REG_FLIP_NORMAL, 32'(flip));
        write_reg(REG_MATERIAL_ID, 32'(mat));
    endtask

    task automatic drain();
        while (ray_queue.size() > 0 || i_valid || hit_queue.size() > 0) @(posedge i_clk);
        repeat (LATENCY_WAIT) @(posedge i_clk);
    endtask

    function automatic longint pick_in(longint lo, longint hi);
        longint span;
        span = hi - lo;
        if (span < 0) return lo + $signed($urandom_range(0, 65535)) - 32768;
        case ($urandom_range(0, 5))
            0: return lo;
            1: return hi;
            default: return lo + longint'({$urandom, $urandom} & 64'h7fff_ffff_ffff_ffff)
                            % (span + 1);
        endcase
    endfunction

    function automatic t_in random_ray();
        t_in r;
        r = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
        return r;
    endfunction

    // aim a ray at a point of the current rectangle, then perturb its interval
    function automatic t_in aimed_ray();
        t_in    r;
        longint d[3], p[3], o[3], t, tmin, tmax;
        int     n, ia, ib;
        case (m_axis)
            AXIS_XY: begin n = 2; ia = 0; ib = 1; end
            AXIS_XZ: begin n = 1; ia = 0; ib = 2; end
            default: begin n = 0; ia = 1; ib = 2; end
        endcase
        for (int i = 0; i < 3; i++)
            d[i] = longint'($urandom_range(0, 1 << 19)) - (1 << 18);
        if ($urandom_range(0, 31) == 0) d[n] = 0;
        t = $urandom_range(0, 40 * 65536);
        p[ia] = pick_in(m_lo_a, m_hi_a);
        p[ib] = pick_in(m_lo_b, m_hi_b);
        p[n]  = m_k;
        for (int i = 0; i < 3; i++) o[i] = sat32(p[i] - ((t * d[i]) >>> FRAC_BITS));
        case ($urandom_range(0, 7))
            0:       tmin = t + $urandom_range(1, 65536);
            1:       tmin = I32_MIN;
            default: tmin = t - $urandom_range(0, 65536);
        endcase
        case ($urandom_range(0, 7))
            0:       tmax = t - $urandom_range(1, 65536);
            1, 2:    tmax = I32_MAX;
            default: tmax = t + $urandom_range(0, 65536);
        endcase
        r.origin_x = 32'(o[0]); r.origin_y = 32'(o[1]); r.origin_z = 32'(o[2]);
        r.dir_x = 32'(d[0]); r.dir_y = 32'(d[1]); r.dir_z = 32'(d[2]);
        r.t_min = 32'(sat32(tmin)); r.t_max = 32'(sat32(tmax));
        return r;
    endfunction

    task automatic random_part(int count);
        for (int i = 0; i < count; i++)
            ray_queue.push_back($urandom_range(0, 4) == 0 ? random_ray() : aimed_ray());
    endtask

    initial begin
        t_in r;
        hold_req = 0;
        i_rst_n = 1'b0;
        i_cfg_valid = 1'b0; i_cfg_index = '0; i_cfg_data = '0;
        m_axis = AXIS_XY; m_lo_a = 0; m_hi_a = 65536; m_lo_b = 0; m_hi_b = 65536;
        m_k = 0; m_flip = 1'b0; m_material = '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed rays against the reset rectangle
        r = '0; ray_queue.push_back(r);
        r = '1; ray_queue.push_back(r);
        r = {8{32'h7fff_ffff}}; ray_queue.push_back(r);
        r = {8{32'h8000_0000}}; ray_queue.push_back(r);
        r = '0; r.origin_x = 32'h8000; r.origin_y = 32'h8000; r.origin_z = 32'h10000;
        r.dir_z = -32'sh10000; r.t_min = 0; r.t_max = 32'h7fff_ffff;
        ray_queue.push_back(r);
        r.dir_z = 0; ray_queue.push_back(r);
        r.dir_z = -32'sh10000; r.t_max = 32'h8000; ray_queue.push_back(r);
        r.t_max = 32'h7fff_ffff; r.t_min = 32'h20000; ray_queue.push_back(r);
        r.t_min = 0; r.origin_x = 0; r.origin_y = 32'h10000; ray_queue.push_back(r);
        r.origin_x = 32'h10001; ray_queue.push_back(r);
        r = '0; r.origin_z = 32'h7fff_ffff; r.dir_z = -1; r.dir_x = 32'h7fff_ffff;
        r.t_min = 32'h8000_0000; r.t_max = 32'h7fff_ffff; ray_queue.push_back(r);
        r.dir_x = 0; r.dir_y = 0; ray_queue.push_back(r);
        r = '0; r.origin_z = 32'h8000_0000; r.dir_z = 32'h7fff_ffff;
        r.t_min = 32'h8000_0000; r.t_max = 32'h7fff_ffff; ray_queue.push_back(r);
        for (int i = 0; i < 6; i++) ray_queue.push_back(aimed_ray());
        random_part(150);
        drain();

        set_rect(AXIS_XY, -5 * 65536, 7 * 65536, -3 * 65536, 2 * 65536, 3 * 65536,
                 1'b0, 16'h1234);
        for (int i = 0; i < 150; i++) ray_queue.push_back(aimed_ray());
        // long receiver hold while rays keep coming
        hold_req++;
        random_part(150);
        drain();

        set_rect(AXIS_XZ, -65536, 65536, 0, 10 * 65536, -2 * 65536, 1'b1, 16'hffff);
        random_part(150);
        drain();

        set_rect(AXIS_YZ, 0, 100 * 65536, -100 * 65536, 0, 50 * 65536, 1'b0, 16'h00a5);
        random_part(150);
        drain();

        set_rect(AXIS_YZ_ALIAS, -65536, 3 * 65536, -65536, 3 * 65536, -65536,
                 1'b1, 16'h5a00);
        random_part(150);
        drain();

        set_rect(AXIS_XY, I32_MIN, I32_MAX, I32_MIN, I32_MAX, I32_MAX, 1'b0, 16'h8001);
        random_part(100);
        drain();
        write_reg(REG_PLANE_K, 32'h8000_0000);
        write_reg(REG_PLANE_AXIS, 32'(AXIS_XZ));
        random_part(100);
        drain();

        // empty bounds: every ray misses
        set_rect(AXIS_XZ, 2 * 65536, 65536, 0, 65536, 0, 1'b1, 16'h0f0f);
        random_part(100);
        drain();

        // zero-width bounds
        set_rect(AXIS_XY, 65536, 65536, -65536, -65536, 4 * 65536, 1'b1, 16'h7777);
        random_part(100);
        drain();

        $display("Rays sent: %0d, hits: %0d, misses: %0d, over all plane forms,",
                 n_rays, n_hits, n_misses);
        $display("full-range, empty and zero-width rectangles and a long output hold.");
        if (n_errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

// File: filelist.f
+incdir+src
src/rri_pkg.sv
src/rri_tdiv.sv
src/axis_rect_ray_intersect.sv
verif/tb_axis_rect_ray_intersect.sv
